### hdl/smrr_pkg.sv
// Shared types, constants and helper functions of the stall margin ratchet regulator.
package smrr_pkg;

	// Configuration register indexes.
	localparam logic [3:0] REG_HANDLER_ENABLE   = 4'd0;
	localparam logic [3:0] REG_NOMINAL_MARGIN   = 4'd1;
	localparam logic [3:0] REG_STALL_LIMIT      = 4'd2;
	localparam logic [3:0] REG_RESTORE_FRACTION = 4'd3;
	localparam logic [3:0] REG_FLOOR_FRACTION   = 4'd4;
	localparam logic [3:0] REG_DROP_FRACTION    = 4'd5;
	localparam logic [3:0] REG_MOTION_EPSILON   = 4'd6;
	localparam logic [3:0] REG_PROXIMITY_BAND   = 4'd7;
	localparam logic [3:0] NUM_REGS             = 4'd8;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	// Action codes of a result beat.
	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_ESCAPE  = 2'd1;
	localparam logic [1:0] ACT_RATCHET = 2'd2;
	localparam logic [1:0] ACT_RESTORE = 2'd3;

	localparam logic [16:0] ONE_Q16       = 17'h1_0000;
	localparam logic [7:0]  STALL_LIMIT_RST = 8'd3;
	localparam logic [7:0]  COUNT_MAX     = 8'hFF;

	// Queue between the classifying front and the regulating back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [31:0]        motion_norm;
		logic               solve_success;
		logic               any_saturated;
		logic               distance_valid;
		logic signed [31:0] closest_distance;
	} smrr_in_t;

	typedef struct packed {
		logic signed [31:0] active_margin;
		logic               margin_written;
		logic [1:0]         action_code;
		logic [7:0]         stall_count;
		logic               is_relaxed;
	} smrr_out_t;

	typedef struct packed {
		logic        handler_enable;
		logic [30:0] nominal_margin;
		logic [7:0]  stall_limit;
		logic [16:0] restore_fraction;
		logic [16:0] floor_fraction_q;
		logic [16:0] drop_fraction;
		logic [31:0] motion_epsilon;
		logic [30:0] proximity_band;
	} smrr_cfg_t;

	// One classified tick as it waits in the queue.
	typedef struct packed {
		logic               stalled;
		logic               success;
		logic               saturated;
		logic               dist_valid;
		logic               penetration;
		logic signed [31:0] distance;
		logic signed [31:0] relief_margin;
		logic signed [32:0] ceil_margin;
	} smrr_work_t;

	// Fractions above one count as one.
	function automatic logic [16:0] frac_clip(input logic [16:0] f);
		return (f > ONE_Q16) ? ONE_Q16 : f;
	endfunction

endpackage

### hdl/smrr_front.sv
// Front stage: takes input beats and classifies each tick for the back stage.
module smrr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  smrr_pkg::smrr_cfg_t cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  smrr_pkg::smrr_in_t  in_data,
	output logic                push,
	output smrr_pkg::smrr_work_t push_data,
	input  logic                queue_full
);
	import smrr_pkg::*;

	logic               front_v_q;
	smrr_work_t         work_s1;
	smrr_work_t         work_d;
	logic signed [32:0] diff;
	logic signed [32:0] nom_ext;
	logic               load;

	assign in_ready = !front_v_q || !queue_full;
	assign load     = in_valid && in_ready;
	assign push      = front_v_q && !queue_full;
	assign push_data = work_s1;

	always_comb begin
		// Distance minus band can only fall below the signed range, never above it.
		diff    = $signed({in_data.closest_distance[31], in_data.closest_distance})
			- $signed({2'b00, cfg.proximity_band});
		nom_ext = $signed({2'b00, cfg.nominal_margin});
		work_d.stalled       = in_data.motion_norm < cfg.motion_epsilon;
		work_d.success       = in_data.solve_success;
		work_d.saturated     = in_data.any_saturated;
		work_d.dist_valid    = in_data.distance_valid;
		work_d.penetration   = in_data.distance_valid && in_data.closest_distance[31];
		work_d.distance      = in_data.closest_distance;
		work_d.relief_margin = (diff[32] != diff[31]) ? 32'sh8000_0000 : diff[31:0];
		work_d.ceil_margin   = (in_data.distance_valid && (diff < nom_ext)) ? diff : nom_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_v_q <= 1'b0;
		end else if (load) begin
			front_v_q <= 1'b1;
		end else if (push) begin
			front_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			work_s1 <= work_d;
		end
	end

endmodule

### hdl/smrr_fifo.sv
// Short queue of classified ticks between the front and back stages.
module smrr_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  smrr_pkg::smrr_work_t push_data,
	output logic                 full,
	input  logic                 pop,
	output smrr_pkg::smrr_work_t pop_data,
	output logic                 empty
);
	import smrr_pkg::*;

	smrr_work_t        entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full     = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = entry_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### hdl/smrr_back.sv
// Back stage: margin and stall counter state, relaxation and restore, result register.
module smrr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smrr_pkg::smrr_cfg_t  cfg,
	input  logic                 cfg_clear,
	input  logic                 empty,
	output logic                 pop,
	input  smrr_pkg::smrr_work_t work,
	output logic                 out_valid,
	input  logic                 out_ready,
	output smrr_pkg::smrr_out_t  out_data
);
	import smrr_pkg::*;

	logic signed [31:0] margin_q;
	logic [7:0]         cnt_q;
	logic               out_valid_q;
	smrr_out_t          out_q;

	// Config-only products, held in registers that load from the configuration each cycle.
	logic [30:0] floor_m_q;
	logic [30:0] restore_step_q;
	logic [30:0] drop_step_q;
	logic [16:0] drop_frac_q;
	logic [47:0] floor_prod;
	logic [47:0] restore_prod;
	logic [47:0] drop_prod;

	logic               binding;
	logic [7:0]         cnt_bump;
	logic [7:0]         cnt_d;
	logic [7:0]         limit;
	logic signed [32:0] gap;
	logic [48:0]        share_prod;
	logic [31:0]        share;
	logic [31:0]        step;
	logic signed [33:0] raised;
	logic signed [33:0] ceil_ext;
	logic signed [33:0] capped;
	logic signed [32:0] lowered;
	logic signed [32:0] floor_ext;
	logic signed [32:0] ratchet_m;
	logic signed [31:0] nom_s;
	logic signed [31:0] margin_d;
	logic [1:0]         action_d;
	smrr_out_t          result_d;

	assign pop       = !empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		floor_prod   = 48'(frac_clip(cfg.floor_fraction_q)) * 48'(cfg.nominal_margin);
		restore_prod = 48'(frac_clip(cfg.restore_fraction)) * 48'(cfg.nominal_margin);
		drop_prod    = 48'(frac_clip(cfg.drop_fraction)) * 48'(cfg.nominal_margin);
	end

	always_ff @(posedge clk) begin
		floor_m_q      <= floor_prod[46:16];
		restore_step_q <= restore_prod[46:16];
		drop_step_q    <= drop_prod[46:16];
		drop_frac_q    <= frac_clip(cfg.drop_fraction);
	end

	always_comb begin
		nom_s    = $signed({1'b0, cfg.nominal_margin});
		binding  = work.dist_valid && (work.distance <= margin_q);
		cnt_bump = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
		limit    = (cfg.stall_limit == '0) ? 8'd1 : cfg.stall_limit;

		if (work.stalled) begin
			cnt_d = cnt_bump;
		end else if (work.success && binding) begin
			cnt_d = cnt_q;
		end else begin
			cnt_d = '0;
		end

		// Restore step: the larger of a share of nominal and a share of the gap.
		gap        = $signed({2'b00, cfg.nominal_margin}) - $signed({margin_q[31], margin_q});
		share_prod = 49'(drop_frac_q) * 49'(gap[31:0]);
		share      = share_prod[47:16];
		step       = (share > {1'b0, restore_step_q}) ? share : {1'b0, restore_step_q};
		raised     = $signed({{2{margin_q[31]}}, margin_q}) + $signed({2'b00, step});
		ceil_ext   = $signed({work.ceil_margin[32], work.ceil_margin});
		capped     = (raised > ceil_ext) ? ceil_ext : raised;

		// Ratchet step, clamped at the floor.
		lowered   = $signed({margin_q[31], margin_q}) - $signed({2'b00, drop_step_q});
		floor_ext = $signed({2'b00, floor_m_q});
		ratchet_m = (lowered < floor_ext) ? floor_ext : lowered;

		margin_d = margin_q;
		action_d = ACT_NONE;
		if (cnt_d >= limit) begin
			priority if (work.penetration && !work.saturated) begin
				margin_d = work.relief_margin;
				action_d = ACT_ESCAPE;
			end else if (binding && !work.saturated
					&& (margin_q > $signed({1'b0, floor_m_q}))) begin
				margin_d = ratchet_m[31:0];
				action_d = ACT_RATCHET;
			end else begin
				// Nothing to apply; the trigger only clears the counter.
				margin_d = margin_q;
				action_d = ACT_NONE;
			end
			cnt_d = '0;
		end else if (work.success && !work.stalled && (margin_q < nom_s)
				&& (capped > $signed({{2{margin_q[31]}}, margin_q}))) begin
			margin_d = capped[31:0];
			action_d = ACT_RESTORE;
		end

		if (cfg.handler_enable) begin
			result_d.active_margin  = margin_d;
			result_d.margin_written = action_d != ACT_NONE;
			result_d.action_code    = action_d;
			result_d.stall_count    = cnt_d;
			result_d.is_relaxed     = margin_d < nom_s;
		end else begin
			result_d.active_margin  = nom_s;
			result_d.margin_written = 1'b0;
			result_d.action_code    = ACT_NONE;
			result_d.stall_count    = cnt_q;
			result_d.is_relaxed     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= '0;
			cnt_q    <= '0;
		end else if (cfg_clear) begin
			margin_q <= nom_s;
			cnt_q    <= '0;
		end else if (pop && cfg.handler_enable) begin
			margin_q <= margin_d;
			cnt_q    <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= result_d;
		end
	end

	a_action_writes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.action_code != ACT_NONE) |-> out_q.margin_written)
		else $error("action reported without a margin write");

	a_relax_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ((out_q.action_code == ACT_ESCAPE)
			|| (out_q.action_code == ACT_RATCHET)) |-> out_q.stall_count == '0)
		else $error("relaxation left the stall counter set");

	a_disabled_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !cfg.handler_enable && !cfg_clear
			|=> (margin_q == $past(margin_q)) && (cnt_q == $past(cnt_q)))
		else $error("state moved while the handler is off");

endmodule

### hdl/stall_margin_ratchet_regulator_core.sv
// Top level of the stall margin ratchet regulator: configuration registers and stage wiring.
// An accepted input beat passes the front register, the queue and the result register.
// Throughput: one tick per cycle while results are taken, set by the margin update loop
// in the back stage, whose combinational multiply, add and clamp feed margin_q directly.
// Reset (arst_n low) restores the register defaults, sets the margin to zero and
// clears the stall counter and the queue; in_ready is already high while reset is held.
module stall_margin_ratchet_regulator_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  smrr_pkg::smrr_in_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output smrr_pkg::smrr_out_t                 out_data,
	input  logic                                cfg_write_en,
	input  logic [smrr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [smrr_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import smrr_pkg::*;

	smrr_cfg_t  cfg_q;
	logic       cfg_clear;
	logic       cfg_clear_q;
	logic       push;
	logic       pop;
	logic       queue_full;
	logic       queue_empty;
	smrr_work_t push_data;
	smrr_work_t pop_data;

	// Any write to a listed register also puts the margin back to nominal and clears
	// the stall counter. Writes to indexes beyond the list are ignored entirely.
	assign cfg_clear = cfg_write_en && (cfg_index < NUM_REGS);

	// The clear is registered and lands in the cycle after the write, so that the margin is reloaded from
	// the nominal value that the same write may have just changed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_clear_q <= 1'b0;
		end else begin
			cfg_clear_q <= cfg_clear;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.handler_enable   <= 1'b0;
			cfg_q.nominal_margin   <= '0;
			cfg_q.stall_limit      <= STALL_LIMIT_RST;
			cfg_q.restore_fraction <= '0;
			cfg_q.floor_fraction_q <= '0;
			cfg_q.drop_fraction    <= '0;
			cfg_q.motion_epsilon   <= '0;
			cfg_q.proximity_band   <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_HANDLER_ENABLE:   cfg_q.handler_enable   <= cfg_data[0];
				REG_NOMINAL_MARGIN:   cfg_q.nominal_margin   <= cfg_data[30:0];
				REG_STALL_LIMIT:      cfg_q.stall_limit      <= cfg_data[7:0];
				REG_RESTORE_FRACTION: cfg_q.restore_fraction <= cfg_data[16:0];
				REG_FLOOR_FRACTION:   cfg_q.floor_fraction_q <= cfg_data[16:0];
				REG_DROP_FRACTION:    cfg_q.drop_fraction    <= cfg_data[16:0];
				REG_MOTION_EPSILON:   cfg_q.motion_epsilon   <= cfg_data[31:0];
				REG_PROXIMITY_BAND:   cfg_q.proximity_band   <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	// The front stage classifies each tick: stall test, penetration, and the
	// escape and ceiling margins that depend only on the measured distance and the configuration.
	smrr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.queue_full(queue_full)
	);

	// The queue lets the front keep taking beats while the result side stalls, until it fills.
	smrr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (queue_full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (queue_empty)
	);

	// The back stage owns the margin and stall counter and registers each result,
	// so a waiting result never blocks the next tick from being popped once taken.
	smrr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cfg_clear(cfg_clear_q),
		.empty    (queue_empty),
		.pop      (pop),
		.work     (pop_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
